// ===== src/tsss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_pkg
// Shared types, codes and fixed-point constants of the settling speed solver.
// ----------------------------------------------------------------------------
package tsss_pkg;

  localparam int unsigned WordW = 64;

  // configuration register indexes
  localparam logic [2:0] CFG_PART_DENS  = 3'd0;
  localparam logic [2:0] CFG_FLUID_DENS = 3'd1;
  localparam logic [2:0] CFG_VISC       = 3'd2;
  localparam logic [2:0] CFG_MAX_ITER   = 3'd3;
  localparam logic [2:0] CFG_TOL        = 3'd4;

  localparam logic [1:0] REGIME_NONE   = 2'd0;
  localparam logic [1:0] REGIME_STOKES = 2'd1;
  localparam logic [1:0] REGIME_TRANS  = 2'd2;
  localparam logic [1:0] REGIME_NEWTON = 2'd3;

  localparam logic [1:0] STATUS_CONV    = 2'd0;
  localparam logic [1:0] STATUS_LIMIT   = 2'd1;
  localparam logic [1:0] STATUS_TURB    = 2'd2;
  localparam logic [1:0] STATUS_INVALID = 2'd3;

  localparam logic [19:0] G_Q16    = 20'd642908;
  localparam logic [31:0] ONE_Q20  = 32'd1048576;
  localparam logic [31:0] C04_Q20  = 32'd419430;
  localparam logic [31:0] C566_Q20 = 32'd5934940;
  localparam logic [31:0] C033_Q20 = 32'd346030;
  localparam logic [31:0] C4_Q20   = 32'd4194304;
  localparam logic [31:0] C24_Q20  = 32'd25165824;

  localparam logic [15:0] RST_PART_DENS  = 16'd2500;
  localparam logic [15:0] RST_FLUID_DENS = 16'd1000;
  localparam logic [39:0] RST_VISC       = 40'd10995116;
  localparam logic [9:0]  RST_MAX_ITER   = 10'd1000;
  localparam logic [31:0] RST_TOL        = 32'd429;

  localparam logic [31:0] RE_HI_1E3 = 32'd1000;
  localparam logic [31:0] RE_HI_2E5 = 32'd200000;

  function automatic logic [31:0] sat32(input logic [WordW-1:0] x);
    sat32 = (x[WordW-1:32] != '0) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

endpackage

// ===== src/terminal_settling_speed_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_settling_speed_solver
// Terminal settling speed of a sphere by fixed-point drag iteration.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one Q0.32 diameter per
//   transfer; the output channel (out_valid_o/out_ready_i) returns speed,
//   Reynolds number, drag coefficient, regime, pass count and status.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   the block is idle; unknown indexes are ignored.
//   One item at a time: in_ready_o is high only when no item is in work and
//   no result is waiting. The multiply-divides and square roots run on one shared
//   multiply-divide unit and one bit-serial square root unit. A result
//   follows the start speed and one or more regime passes, with a shorter
//   pass in the Stokes regime and the shortest one for the pass that exits
//   as turbulent; an invalid input passes through S_PREP and S_INV before
//   its result is valid.
//   Reset restores the default fluid and particle settings and drops any
//   item in work. A stalled receiver holds the result on the ports and the
//   block takes no new item until it is transferred.
// ----------------------------------------------------------------------------
module terminal_settling_speed_solver import tsss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] diameter_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] speed_o,
  output logic [31:0] reynolds_o,
  output logic [31:0] drag_coeff_o,
  output logic [1:0]  regime_o,
  output logic [9:0]  iterations_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [39:0] cfg_wdata_i
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PREP  = 14'b00000000000010,
    S_ADIV  = 14'b00000000000100,
    S_VDIV  = 14'b00000000001000,
    S_VSQ   = 14'b00000000010000,
    S_REDIV = 14'b00000000100000,
    S_CLS   = 14'b00000001000000,
    S_SRE   = 14'b00000010000000,
    S_C24   = 14'b00000100000000,
    S_CT    = 14'b00001000000000,
    S_UPD   = 14'b00010000000000,
    S_RES   = 14'b00100000000000,
    S_DONE  = 14'b01000000000000,
    S_INV   = 14'b10000000000000
  } seq_state_e;

  seq_state_e state_q, state_d;

  logic [15:0] pd_q, fd_q;
  logic [39:0] nu_q;
  logic [9:0]  maxit_q, iter_q;
  logic [31:0] tol_q, d_q, v_q, old_q, cw_q, s_q, diff_q;
  logic [37:0] xa_q;
  logic [63:0] a16_q, re_q;
  logic [1:0]  regime_q;
  logic        first_q, go_q;

  logic             md_start, md_done, sq_start, sq_done, is_op;
  logic [WordW-1:0] md_x, md_y, md_z, md_q, sq_x;
  logic [31:0]      sq_root, ct_sat;
  logic [17:0]      fd3;
  logic [33:0]      cw_sum;
  logic             fin;
  logic [1:0]       fin_status;

  assign fd3    = 18'({2'b0, fd_q} + {1'b0, fd_q, 1'b0});
  assign ct_sat = sat32(md_q);
  assign cw_sum = {2'b0, cw_q} + {2'b0, ct_sat}
                + {2'b0, (regime_q == REGIME_TRANS) ? C04_Q20 : C033_Q20};

  always_comb begin
    md_x = '0;
    md_y = '0;
    md_z = '0;
    case (state_q)
      S_ADIV: begin
        md_x = {26'd0, xa_q};
        md_y = 64'd65536;
        md_z = {46'd0, fd3};
      end
      S_VDIV: begin
        md_x = a16_q;
        md_y = {32'd0, d_q};
        md_z = {32'd0, cw_q};
      end
      S_REDIV: begin
        md_x = {16'd0, v_q, 16'd0};
        md_y = {32'd0, d_q};
        md_z = {24'd0, nu_q};
      end
      S_C24: begin
        md_x = {32'd0, C24_Q20};
        md_y = 64'h1_0000_0000;
        md_z = re_q;
      end
      S_CT: begin
        md_x = {32'd0, (regime_q == REGIME_TRANS) ? C4_Q20 : C566_Q20};
        md_y = 64'd65536;
        md_z = {32'd0, s_q};
      end
      S_RES: begin
        md_x = {32'd0, diff_q};
        md_y = 64'h1_0000_0000;
        md_z = {32'd0, old_q};
      end
      default: ;
    endcase
  end

  assign sq_x     = (state_q == S_SRE) ? re_q : md_q;
  assign md_start = go_q && (state_q == S_ADIV || state_q == S_VDIV || state_q == S_REDIV
                    || state_q == S_C24 || state_q == S_CT || state_q == S_RES);
  assign sq_start = go_q && (state_q == S_VSQ || state_q == S_SRE);

  tsss_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(md_start),
    .x_i    (md_x),
    .y_i    (md_y),
    .z_i    (md_z),
    .done_o (md_done),
    .q_o    (md_q)
  );

  tsss_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .x_i    (sq_x),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    fin        = 1'b0;
    fin_status = STATUS_CONV;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_PREP;
      S_PREP: begin
        if (d_q == '0 || fd_q == '0 || pd_q <= fd_q) begin
          state_d = S_INV;
        end else begin
          state_d = S_ADIV;
        end
      end
      S_ADIV:  if (md_done) state_d = S_VDIV;
      S_VDIV:  if (md_done) state_d = S_VSQ;
      S_VSQ:   if (sq_done) state_d = first_q ? S_REDIV : S_RES;
      S_REDIV: if (md_done) state_d = S_CLS;
      S_CLS: begin
        if (re_q[63:30] == '0) begin
          state_d = S_C24;
        end else if (re_q[63:32] < RE_HI_2E5) begin
          state_d = S_SRE;
        end else begin
          fin        = 1'b1;
          fin_status = STATUS_TURB;
          state_d    = S_DONE;
        end
      end
      S_SRE: if (sq_done) state_d = S_C24;
      S_C24: if (md_done) state_d = (regime_q == REGIME_STOKES) ? S_UPD : S_CT;
      S_CT:  if (md_done) state_d = S_UPD;
      S_UPD: state_d = S_VDIV;
      S_RES: begin
        if (md_done) begin
          if (md_q <= {32'd0, tol_q}) begin
            fin        = 1'b1;
            fin_status = STATUS_CONV;
            state_d    = S_DONE;
          end else if (iter_q >= maxit_q) begin
            fin        = 1'b1;
            fin_status = STATUS_LIMIT;
            state_d    = S_DONE;
          end else begin
            state_d = S_REDIV;
          end
        end
      end
      S_INV:  state_d = S_DONE;
      S_DONE: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign is_op = (state_d == S_ADIV || state_d == S_VDIV || state_d == S_VSQ
                  || state_d == S_REDIV || state_d == S_SRE || state_d == S_C24
                  || state_d == S_CT || state_d == S_RES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q    <= 1'b0;
      pd_q    <= RST_PART_DENS;
      fd_q    <= RST_FLUID_DENS;
      nu_q    <= RST_VISC;
      maxit_q <= RST_MAX_ITER;
      tol_q   <= RST_TOL;
    end else begin
      state_q <= state_d;
      go_q    <= is_op && (state_d != state_q);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PART_DENS:  pd_q    <= cfg_wdata_i[15:0];
          CFG_FLUID_DENS: fd_q    <= cfg_wdata_i[15:0];
          CFG_VISC:       nu_q    <= cfg_wdata_i;
          CFG_MAX_ITER:   maxit_q <= cfg_wdata_i[9:0];
          CFG_TOL:        tol_q   <= cfg_wdata_i[31:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_valid_i) d_q <= diameter_i;
      S_PREP: begin
        xa_q     <= 38'({pd_q - fd_q, 2'b00} * G_Q16);
        cw_q     <= ONE_Q20;
        re_q     <= '0;
        regime_q <= REGIME_NONE;
        iter_q   <= '0;
        first_q  <= 1'b1;
      end
      S_ADIV: if (md_done) a16_q <= {md_q[WordW-5:0], 4'd0};
      S_VSQ: begin
        if (sq_done) begin
          v_q     <= sq_root;
          first_q <= 1'b0;
          diff_q  <= (sq_root >= old_q) ? sq_root - old_q : old_q - sq_root;
        end
      end
      S_REDIV: if (md_done) re_q <= md_q;
      S_CLS: begin
        if (re_q[63:30] == '0) begin
          regime_q <= REGIME_STOKES;
        end else if (re_q[63:32] < RE_HI_2E5) begin
          regime_q <= (re_q[63:32] < RE_HI_1E3) ? REGIME_TRANS : REGIME_NEWTON;
        end
      end
      S_SRE: if (sq_done) s_q <= sq_root;
      S_C24: if (md_done) cw_q <= sat32(md_q);
      S_CT:  if (md_done) cw_q <= sat32({30'd0, cw_sum});
      S_UPD: begin
        iter_q <= iter_q + 10'd1;
        old_q  <= v_q;
      end
      default: ;
    endcase

    if (state_q == S_INV) begin
      speed_o      <= '0;
      reynolds_o   <= '0;
      drag_coeff_o <= '0;
      regime_o     <= REGIME_NONE;
      iterations_o <= '0;
      status_o     <= STATUS_INVALID;
    end else if (fin) begin
      speed_o      <= v_q;
      reynolds_o   <= sat32({18'd0, re_q[63:18]});
      drag_coeff_o <= cw_q;
      regime_o     <= regime_q;
      iterations_o <= iter_q;
      status_o     <= fin_status;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_DONE);

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and result valid together");

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_INVALID |-> speed_o == '0 && iterations_o == '0)
    else $error("invalid result carries data");

  a_conv_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_CONV |-> iterations_o != '0)
    else $error("converged without a pass");

  a_turb_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_TURB && iterations_o == '0
    |-> drag_coeff_o == ONE_Q20 && regime_o == REGIME_NONE)
    else $error("first-pass turbulent exit lost start drag");

  a_unit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(md_start && sq_start)) else $error("both units started together");
`endif

endmodule

// ===== src/tsss_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_muldiv
// Iterative floor(x*y/z): 128-bit product from four 32x32 partial products,
// then a restoring divide, one quotient bit per cycle. Saturates on overflow.
// ----------------------------------------------------------------------------
module tsss_muldiv import tsss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] x_i,
  input  logic [WordW-1:0] y_i,
  input  logic [WordW-1:0] z_i,
  output logic             done_o,
  output logic [WordW-1:0] q_o
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_MUL  = 4'b0010,
    M_CHK  = 4'b0100,
    M_DIV  = 4'b1000
  } md_state_e;

  md_state_e          state_q;
  logic [WordW-1:0]   x_q, y_q, z_q, rem_q, q_q, pp_q;
  logic [2*WordW-1:0] acc_q, pp_ext;
  logic [1:0]         sh_q;
  logic [6:0]         cnt_q;
  logic               done_q;
  logic [31:0]        mul_a, mul_b;
  logic [WordW:0]     div_sh;
  logic               div_take;

  assign mul_a = cnt_q[1] ? x_q[63:32] : x_q[31:0];
  assign mul_b = cnt_q[0] ? y_q[63:32] : y_q[31:0];

  always_comb begin
    case (sh_q)
      2'd0:    pp_ext = {64'd0, pp_q};
      2'd1:    pp_ext = {32'd0, pp_q, 32'd0};
      2'd2:    pp_ext = {pp_q, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  // shift next dividend bit in; the bit shifted out of the remainder forces a take
  assign div_sh   = {rem_q, acc_q[WordW-1]};
  assign div_take = div_sh[WordW] || (div_sh[WordW-1:0] >= z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            state_q <= M_MUL;
            cnt_q   <= '0;
          end
        end
        M_MUL: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd4) begin
            state_q <= M_CHK;
          end
        end
        M_CHK: begin
          if (z_q == '0 || acc_q[2*WordW-1:WordW] >= z_q) begin
            state_q <= M_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= M_DIV;
            cnt_q   <= '0;
          end
        end
        M_DIV: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(WordW - 1)) begin
            state_q <= M_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          x_q   <= x_i;
          y_q   <= y_i;
          z_q   <= z_i;
          acc_q <= '0;
        end
      end
      M_MUL: begin
        pp_q <= WordW'(mul_a * mul_b);
        sh_q <= 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
        if (cnt_q != 7'd0) begin
          acc_q <= acc_q + pp_ext;
        end
      end
      M_CHK: begin
        rem_q <= acc_q[2*WordW-1:WordW];
        q_q   <= '1;
      end
      M_DIV: begin
        acc_q[WordW-1:0] <= {acc_q[WordW-2:0], 1'b0};
        rem_q <= div_take ? WordW'(div_sh - {1'b0, z_q}) : div_sh[WordW-1:0];
        q_q   <= {q_q[WordW-2:0], div_take};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

// ===== src/tsss_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_isqrt
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tsss_isqrt import tsss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WordW-1:0] x_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic             busy_q, done_q;
  logic [4:0]       cnt_q;
  logic [WordW-1:0] x_q, r_q, b_q, trial;

  assign trial = r_q + b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (start_i) begin
        x_q <= x_i;
        r_q <= '0;
        b_q <= {2'b01, 62'd0};
      end
    end else begin
      if (x_q >= trial) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

// ===== tb/terminal_settling_speed_solver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_settling_speed_solver_tb
// Self-checking bench for the settling speed solver.
// Diameters are driven through a valid/ready driver that idles at random.
// The fluid and particle settings are changed between phases while the
// solver is idle. Every accepted diameter is run through an in-bench
// fixed-point model of the iteration. The monitor checks each returned result
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module terminal_settling_speed_solver_tb;
  import tsss_pkg::*;

  localparam int unsigned CycleLimit = 60_000_000;

  typedef struct packed {
    logic [31:0] speed;
    logic [31:0] reynolds;
    logic [31:0] drag_coeff;
    logic [1:0]  regime;
    logic [9:0]  iterations;
    logic [1:0]  status;
  } settle_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] diameter_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] speed_o, reynolds_o, drag_coeff_o;
  logic [1:0]  regime_o, status_o;
  logic [9:0]  iterations_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [39:0] cfg_wdata_i = '0;

  terminal_settling_speed_solver i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the solver settings
  logic [15:0] rho_part = RST_PART_DENS;
  logic [15:0] rho_fluid = RST_FLUID_DENS;
  logic [39:0] visc = RST_VISC;
  logic [9:0]  iter_cap = RST_MAX_ITER;
  logic [31:0] tol = RST_TOL;

  logic [31:0] diam_pending[$];
  settle_res_t settle_expected[$];
  int unsigned errors = 0, n_results = 0, n_turb = 0, n_conv = 0, n_limit = 0;
  int unsigned n_invalid = 0, cycles = 0;
  bit in_done = 0, out_done = 0, hold_sender = 0;
  int unsigned in_gap = 0, out_stall = 0;

  function automatic logic [63:0] muldiv(input logic [63:0] x, input logic [63:0] y,
                                         input logic [63:0] z);
    logic [127:0] prod;
    logic [127:0] q;
    prod = {64'd0, x} * {64'd0, y};
    if (z == 0 || prod[127:64] >= z) return '1;
    q = prod / {64'd0, z};
    return q[63:0];
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] clip32(input logic [63:0] x);
    return (x > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : x;
  endfunction

  function automatic settle_res_t solve_settling(input logic [31:0] d);
    settle_res_t r;
    logic [63:0] a16, v, v_old, re, cw, s, diff, resid, dd;
    logic [1:0]  reg_sel;
    logic [9:0]  n;
    r = '0;
    dd = {32'd0, d};
    if (d == 0 || rho_fluid == 0 || rho_part <= rho_fluid) begin
      r.status = STATUS_INVALID;
      return r;
    end
    a16 = muldiv(64'd4 * (rho_part - rho_fluid) * 64'(G_Q16), 64'd1 << 16,
                 64'd3 * rho_fluid) << 4;
    cw = 64'(ONE_Q20);
    re = 0;
    reg_sel = REGIME_NONE;
    n = 0;
    v = clip32(isqrt(muldiv(a16, dd, cw)));
    while (1) begin
      re = muldiv(v << 16, dd, {24'd0, visc});
      if (re < (64'd1 << 30)) begin
        cw = clip32(muldiv(64'(C24_Q20), 64'd1 << 32, re));
        reg_sel = REGIME_STOKES;
      end else if (re < (64'd200000 << 32)) begin
        s = isqrt(re);
        cw = clip32(muldiv(64'(C24_Q20), 64'd1 << 32, re));
        if (re < (64'd1000 << 32)) begin
          cw = cw + clip32(muldiv(64'(C4_Q20), 64'd1 << 16, s)) + 64'(C04_Q20);
          reg_sel = REGIME_TRANS;
        end else begin
          cw = cw + clip32(muldiv(64'(C566_Q20), 64'd1 << 16, s)) + 64'(C033_Q20);
          reg_sel = REGIME_NEWTON;
        end
        cw = clip32(cw);
      end else begin
        r.status = STATUS_TURB;
        break;
      end
      n = n + 10'd1;
      v_old = v;
      v = clip32(isqrt(muldiv(a16, dd, cw)));
      diff = (v >= v_old) ? v - v_old : v_old - v;
      resid = muldiv(diff, 64'd1 << 32, v_old);
      if (resid <= {32'd0, tol}) begin
        r.status = STATUS_CONV;
        break;
      end
      if (n >= iter_cap) begin
        r.status = STATUS_LIMIT;
        break;
      end
    end
    r.speed = v[31:0];
    r.reynolds = clip32(re >> 18);
    r.drag_coeff = cw[31:0];
    r.regime = reg_sel;
    r.iterations = n;
    return r;
  endfunction

  // driver: diameters change on the falling edge
  always @(negedge clk_i) begin
    if (in_valid_i && in_done) begin
      in_valid_i <= 1'b0;
      in_done = 0;
      in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    end else if (!in_valid_i) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (diam_pending.size() > 0 && !hold_sender) begin
        diameter_i <= diam_pending.pop_front();
        in_valid_i <= 1'b1;
      end
    end
    if (out_done) begin
      out_done = 0;
      out_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    settle_res_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, settle_expected.size());
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      settle_expected.push_back(solve_settling(diameter_i));
      in_done = 1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_done = 1;
      n_results++;
      if (settle_expected.size() == 0) begin
        $display("%0t: result with nothing outstanding, speed %h status %0d",
                 $time, speed_o, status_o);
        errors++;
      end else begin
        e = settle_expected.pop_front();
        case (status_o)
          STATUS_CONV:  n_conv++;
          STATUS_LIMIT: n_limit++;
          STATUS_TURB:  n_turb++;
          default:      n_invalid++;
        endcase
        if (speed_o !== e.speed || reynolds_o !== e.reynolds ||
            drag_coeff_o !== e.drag_coeff || regime_o !== e.regime ||
            iterations_o !== e.iterations || status_o !== e.status) begin
          errors++;
          $display("%0t: mismatch exp spd %h re %h cw %h rg %0d it %0d st %0d", $time,
                   e.speed, e.reynolds, e.drag_coeff, e.regime, e.iterations, e.status);
          $display("%0t:          got spd %h re %h cw %h rg %0d it %0d st %0d", $time,
                   speed_o, reynolds_o, drag_coeff_o, regime_o, iterations_o, status_o);
        end
      end
    end
  end

  task automatic drain();
    wait (diam_pending.size() == 0 && !in_valid_i && settle_expected.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_PART_DENS:  rho_part = val[15:0];
      CFG_FLUID_DENS: rho_fluid = val[15:0];
      CFG_VISC:       visc = val;
      CFG_MAX_ITER:   iter_cap = val[9:0];
      CFG_TOL:        tol = val[31:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_fluid(input logic [15:0] pd, input logic [15:0] fd,
                           input logic [39:0] nu, input logic [9:0] cap,
                           input logic [31:0] tl);
    drain();
    write_reg(CFG_PART_DENS, {24'd0, pd});
    write_reg(CFG_FLUID_DENS, {24'd0, fd});
    write_reg(CFG_VISC, nu);
    write_reg(CFG_MAX_ITER, {30'd0, cap});
    write_reg(CFG_TOL, {8'd0, tl});
  endtask

  task automatic queue_diameters(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0:       diam_pending.push_back($urandom_range(0, 3));
        1, 2:    diam_pending.push_back($urandom);
        default: diam_pending.push_back($urandom_range(4000, 50_000_000));
      endcase
    end
  endtask

  initial begin
    logic [15:0] pd;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: invalid, tiny, huge and typical diameters
    diam_pending.push_back(32'd0);
    diam_pending.push_back(32'd1);
    diam_pending.push_back(32'hFFFF_FFFF);
    diam_pending.push_back(32'd429497);
    diam_pending.push_back(32'd4294967);
    diam_pending.push_back(32'd42949673);
    diam_pending.push_back(32'h8000_0000);
    diam_pending.push_back(32'h5555_5555);
    diam_pending.push_back(32'hAAAA_AAAA);
    drain();
    // unused index must leave the settings untouched
    write_reg(3'd7, 40'hFF_FFFF_FFFF);
    diam_pending.push_back(32'd4294967);
    // sender holds until every result is back
    hold_sender = 1;
    wait (settle_expected.size() == 0);
    repeat (5) @(posedge clk_i);
    hold_sender = 0;
    drain();

    set_fluid(16'd2500, 16'd1000, RST_VISC, 10'd4, 32'd4294967);
    queue_diameters(50);
    set_fluid(16'd65535, 16'd1, 40'd1, 10'd3, 32'd0);
    diam_pending.push_back(32'd1);
    queue_diameters(20);
    set_fluid(16'd0, 16'd1000, RST_VISC, 10'd2, 32'd429);
    queue_diameters(10);
    set_fluid(16'd65535, 16'd65535, RST_VISC, 10'd2, 32'd429);
    queue_diameters(10);
    set_fluid(16'd1100, 16'd1000, 40'hFF_FFFF_FFFF, 10'd8, 32'd42949673);
    queue_diameters(40);
    set_fluid(16'd7800, 16'd1000, 40'd1099511, 10'd2, $urandom);
    queue_diameters(50);
    set_fluid(16'd2500, 16'd1000, RST_VISC, 10'd0, 32'd429);
    queue_diameters(25);
    set_fluid(16'd2500, 16'd1000, RST_VISC, 10'd1023, 32'hFFFF_FFFF);
    queue_diameters(20);
    repeat (4) begin
      pd = 16'($urandom_range(2, 65535));
      set_fluid(pd, 16'($urandom_range(1, pd - 1)),
                {$urandom, 8'(1 + $urandom_range(0, 254))},
                10'($urandom_range(1, 5)), $urandom);
      queue_diameters(15);
    end
    drain();
    repeat (200) @(posedge clk_i);

    $display("Checked %0d results: %0d converged, %0d at limit, %0d turbulent, %0d invalid",
             n_results, n_conv, n_limit, n_turb, n_invalid);
    $display("Covered reset, extreme and random fluid settings with random handshake gaps");
    if (errors == 0 && settle_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
